FILE: rtl/core/mmga_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmga_pkg
// Shared types, codes and constants of the min-metric grant arbiter.
// ----------------------------------------------------------------------------
package mmga_pkg;

   // fixed field widths
   localparam int ID_W            = 6;    // holds any requester index up to 63
   localparam int CNT_W           = 16;   // served counts and grant total
   localparam int TICK_W          = 32;   // arrival tick counter
   localparam int CSR_DATA_W      = 16;   // widest config register

   // parameter defaults and reset values
   localparam int NUM_REQUESTERS_DEF = 16;
   localparam int METRIC_BITS_DEF    = 32;
   localparam logic [CNT_W-1:0] SERVE_LIMIT_RST = 16'd100;

   // input operation codes
   typedef enum logic [1:0] {
      OP_TICK    = 2'd0,
      OP_REQUEST = 2'd1,
      OP_PICK    = 2'd2,
      OP_NOP     = 2'd3
   } op_type;

   // metric policy codes
   typedef enum logic [1:0] {
      POL_FEWEST  = 2'd0,
      POL_MOST    = 2'd1,
      POL_ARRIVAL = 2'd2,
      POL_FIXED   = 2'd3
   } policy_type;

   // config register indexes
   typedef enum logic [1:0] {
      CSR_POLICY      = 2'd0,
      CSR_PAIR_MODE   = 2'd1,
      CSR_SERVE_LIMIT = 2'd2
   } csr_type;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_GRANT
   } state_type;

   // command broadcast from the controller to every cell
   typedef struct packed {
      logic              wr;        // write a request metric
      logic [ID_W-1:0]   wr_id;
      logic              clr;       // clear the picked word to idle
      logic [ID_W-1:0]   pick_id;
      logic              inc_pick;  // count a grant for pick_id
      logic [ID_W-1:0]   held_id;
      logic              inc_held;  // count a grant for held_id
      policy_type        policy;
      logic [TICK_W-1:0] tick;
   } cmd_type;

endpackage

FILE: rtl/core/mmga_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmga_cell
// One requester slot: priority word, served count and one stage of the
// running-minimum chain.
// ----------------------------------------------------------------------------
module mmga_cell import mmga_pkg::*; #(
   parameter int MetricBits = METRIC_BITS_DEF,
   parameter int Index      = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   input  logic [MetricBits-1:0] best_word_in,
   input  logic [ID_W-1:0]       best_id_in,
   output logic [MetricBits-1:0] best_word_out,
   output logic [ID_W-1:0]       best_id_out
);

   localparam int CmpW = ((MetricBits > TICK_W) ? MetricBits : TICK_W) + 1;
   localparam logic [ID_W-1:0] MyId = ID_W'(Index);
   localparam logic [MetricBits-1:0] IdleWord = {MetricBits{1'b1}};

   logic [MetricBits-1:0] word_ff, word_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [MetricBits-1:0] best_word_ff;
   logic [ID_W-1:0]       best_id_ff;

   logic [CmpW-1:0] idle_ext, cnt_ext, raw, clamped, most, metric_full;
   logic [1:0]      inc_n;
   logic [CNT_W:0]  cnt_sum;

   // metric for a request, by policy
   always_comb begin
      idle_ext = CmpW'(IdleWord);
      cnt_ext  = CmpW'(count_ff);
      case (cmd.policy)
         POL_ARRIVAL: raw = CmpW'(cmd.tick) & idle_ext;
         POL_FIXED:   raw = CmpW'(MyId);
         default:     raw = cnt_ext;
      endcase
      clamped = (raw >= idle_ext) ? idle_ext - CmpW'(1) : raw;
      most    = (idle_ext > cnt_ext + CmpW'(1)) ? idle_ext - cnt_ext - CmpW'(1) : '0;
      metric_full = (cmd.policy == POL_MOST) ? most : clamped;
   end

   // word update: request write or clear on grant
   always_comb begin
      word_in = word_ff;
      if (cmd.wr && (cmd.wr_id == MyId)) begin
         word_in = metric_full[MetricBits-1:0];
      end else if (cmd.clr && (cmd.pick_id == MyId)) begin
         word_in = IdleWord;
      end
   end

   // saturating served count, up to two grants at once
   always_comb begin
      inc_n = {1'b0, (cmd.inc_pick && (cmd.pick_id == MyId))}
            + {1'b0, (cmd.inc_held && (cmd.held_id == MyId))};
      cnt_sum  = {1'b0, count_ff} + (CNT_W+1)'(inc_n);
      count_in = cnt_sum[CNT_W] ? {CNT_W{1'b1}} : cnt_sum[CNT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff  <= IdleWord;
         count_ff <= '0;
      end else begin
         word_ff  <= word_in;
         count_ff <= count_in;
      end
   end

   // running minimum stage, lower index wins ties
   always_ff @(posedge clock) begin
      if (word_ff < best_word_in) begin
         best_word_ff <= word_ff;
         best_id_ff   <= MyId;
      end else begin
         best_word_ff <= best_word_in;
         best_id_ff   <= best_id_in;
      end
   end

   assign best_word_out = best_word_ff;
   assign best_id_out   = best_id_ff;

endmodule

FILE: rtl/core/mmga_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmga_ctrl
// Sequencer: config registers, tick and grant totals, pair hold, scan wait
// and the result register.
// ----------------------------------------------------------------------------
module mmga_ctrl import mmga_pkg::*; #(
   parameter int NumRequesters = NUM_REQUESTERS_DEF,
   parameter int MetricBits    = METRIC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_operation,
   input  logic [3:0]            req_requester_id,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [1:0]            rsp_grant_count,
   output logic [3:0]            rsp_first_id,
   output logic [3:0]            rsp_second_id,
   output logic                  rsp_done_res,
   input  logic                  csr_wr_en,
   input  logic [1:0]            csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic [MetricBits-1:0] tail_word,
   input  logic [ID_W-1:0]       tail_id,
   output cmd_type               cmd
);

   localparam logic [MetricBits-1:0] IdleWord = {MetricBits{1'b1}};
   localparam logic [ID_W-1:0] ScanLast = ID_W'(NumRequesters - 1);

   state_type         state_ff, state_in;
   logic [ID_W-1:0]   scan_cnt_ff, scan_cnt_in;
   policy_type        policy_ff;
   logic              pair_mode_ff;
   logic [CNT_W-1:0]  limit_ff;
   logic [TICK_W-1:0] tick_ff, tick_in;
   logic [CNT_W-1:0]  total_ff, total_in;
   logic              pend_ff, pend_in;
   logic [ID_W-1:0]   held_ff, held_in;
   logic              rsp_valid_ff;
   logic [1:0]        gcount_ff, gcount_in;
   logic [ID_W-1:0]   fid_ff, fid_in, sid_ff, sid_in;
   logic              done_ff, done_in;

   logic              out_free, accept, grant_fire, found, rsp_load;
   op_type            op;
   logic [CNT_W:0]    total_p2;

   assign op         = op_type'(req_operation);
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign req_ready  = (state_ff == ST_IDLE) && out_free;
   assign accept     = req_valid && req_ready;
   assign grant_fire = (state_ff == ST_GRANT) && out_free;
   assign found      = (tail_word != IdleWord) && (total_ff < limit_ff);
   assign total_p2   = {1'b0, total_ff} + (CNT_W+1)'(2);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (accept && (op == OP_PICK)) state_in = ST_SCAN;
         ST_SCAN:  if (scan_cnt_ff == '0) state_in = ST_GRANT;
         ST_GRANT: if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // scan wait counter: chain settles one cell per cycle
   always_comb begin
      scan_cnt_in = scan_cnt_ff;
      if (accept && (op == OP_PICK)) begin
         scan_cnt_in = ScanLast;
      end else if ((state_ff == ST_SCAN) && (scan_cnt_ff != '0)) begin
         scan_cnt_in = scan_cnt_ff - ID_W'(1);
      end
   end

   // command, counters and result
   always_comb begin
      cmd          = '0;
      cmd.policy   = policy_ff;
      cmd.tick     = tick_ff;
      cmd.held_id  = held_ff;
      tick_in      = tick_ff;
      total_in     = total_ff;
      pend_in      = pend_ff;
      held_in      = held_ff;
      rsp_load     = 1'b0;
      gcount_in    = 2'd0;
      fid_in       = '0;
      sid_in       = '0;
      if (accept) begin
         case (op)
            OP_TICK: begin
               tick_in  = tick_ff + TICK_W'(1);
               rsp_load = 1'b1;
            end
            OP_REQUEST: begin
               if ((ID_W+1)'(req_requester_id) < (ID_W+1)'(NumRequesters)) begin
                  cmd.wr    = 1'b1;
                  cmd.wr_id = ID_W'(req_requester_id);
               end
               rsp_load = 1'b1;
            end
            OP_PICK: rsp_load = 1'b0;
            default: rsp_load = 1'b1;
         endcase
      end
      if (grant_fire) begin
         rsp_load = 1'b1;
         if (found) begin
            cmd.clr     = 1'b1;
            cmd.pick_id = tail_id;
            if (pend_ff) begin
               // complete the held pair
               cmd.inc_pick = 1'b1;
               cmd.inc_held = 1'b1;
               pend_in      = 1'b0;
               total_in     = total_p2[CNT_W] ? {CNT_W{1'b1}} : total_p2[CNT_W-1:0];
               gcount_in    = 2'd2;
               fid_in       = tail_id;
               sid_in       = held_ff;
            end else if (pair_mode_ff) begin
               pend_in = 1'b1;
               held_in = tail_id;
            end else begin
               cmd.inc_pick = 1'b1;
               total_in     = (total_ff == {CNT_W{1'b1}}) ? total_ff
                                                          : total_ff + CNT_W'(1);
               gcount_in    = 2'd1;
               fid_in       = tail_id;
            end
         end
      end
      done_in = (total_in >= limit_ff);
   end

   // control and arbitration state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         scan_cnt_ff  <= '0;
         tick_ff      <= '0;
         total_ff     <= '0;
         pend_ff      <= 1'b0;
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         scan_cnt_ff <= scan_cnt_in;
         tick_ff     <= tick_in;
         total_ff    <= total_in;
         pend_ff     <= pend_in;
         held_ff     <= held_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // result payload register
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         gcount_ff <= gcount_in;
         fid_ff    <= fid_in;
         sid_ff    <= sid_in;
         done_ff   <= done_in;
      end
   end

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff    <= POL_FEWEST;
         pair_mode_ff <= 1'b0;
         limit_ff     <= SERVE_LIMIT_RST;
      end else if (csr_wr_en) begin
         unique case (csr_type'(csr_index))
            CSR_POLICY:      policy_ff    <= policy_type'(csr_wdata[1:0]);
            CSR_PAIR_MODE:   pair_mode_ff <= csr_wdata[0];
            CSR_SERVE_LIMIT: limit_ff     <= csr_wdata[CNT_W-1:0];
            default:         limit_ff     <= limit_ff;
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_grant_count = gcount_ff;
   assign rsp_first_id    = fid_ff[3:0];
   assign rsp_second_id   = sid_ff[3:0];
   assign rsp_done_res    = done_ff;

`ifndef NO_ASSERTIONS
   // a pick always starts a full chain scan
   a_pick_scans: assert property (@(posedge clock) disable iff (reset)
      (accept && (op == OP_PICK)) |=> (state_ff == ST_SCAN))
      else $error("pick transfer did not start a scan");

   // a completed pair releases the held requester
   a_pair_release: assert property (@(posedge clock) disable iff (reset)
      (grant_fire && found && pend_ff) |=> !pend_ff)
      else $error("held requester not released after pair grant");

   // grant total never goes down outside reset
   a_total_mono: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (total_ff >= $past(total_ff)))
      else $error("grant total decreased");

   // a held requester is always a real slot
   a_held_range: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> ((ID_W+1)'(held_ff) < (ID_W+1)'(NumRequesters)))
      else $error("held requester out of range");
`endif

endmodule

FILE: rtl/core/min_metric_grant_arbiter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_metric_grant_arbiter
// Arbiter over a row of requester cells, granting the smallest metric.
// ----------------------------------------------------------------------------
// Usage: the req_ channel carries one operation per transfer: tick, request
// from req_requester_id, pick, or no operation. Every transfer yields exactly
// one rsp_ transfer with grant count, ids and the done flag. The csr_ port
// writes policy, pair mode and serve limit; the user writes it only while
// the block is idle, which the block does not enforce. Tick, request and
// no-operation items give their result in the cycle after the transfer and
// can follow each other every cycle while rsp_ready stays high. A pick
// scans while the running minimum ripples through the row, one cell per cycle.
// The result sits in an output register; a new item is taken while it waits
// if the receiver takes it in the same cycle. While rsp_ready is low with a
// result pending, req_ready stays low and nothing is lost.
// Reset sets every priority word idle, clears served counts, tick and grant
// totals and the pair hold, and loads the register defaults.
// ----------------------------------------------------------------------------
module min_metric_grant_arbiter import mmga_pkg::*; #(
   parameter int NumRequesters = NUM_REQUESTERS_DEF,
   parameter int MetricBits    = METRIC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_operation,
   input  logic [3:0]            req_requester_id,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [1:0]            rsp_grant_count,
   output logic [3:0]            rsp_first_id,
   output logic [3:0]            rsp_second_id,
   output logic                  rsp_done_res,
   input  logic                  csr_wr_en,
   input  logic [1:0]            csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cmd_type               cmd;
   logic [MetricBits-1:0] chain_word [NumRequesters+1];
   logic [ID_W-1:0]       chain_id   [NumRequesters+1];

   // head of the chain starts from the idle word
   assign chain_word[0] = {MetricBits{1'b1}};
   assign chain_id[0]   = '0;

   // row of requester cells
   for (genvar gi = 0; gi < NumRequesters; gi++) begin : g_cell
      mmga_cell #(
         .MetricBits (MetricBits),
         .Index      (gi)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .cmd           (cmd),
         .best_word_in  (chain_word[gi]),
         .best_id_in    (chain_id[gi]),
         .best_word_out (chain_word[gi+1]),
         .best_id_out   (chain_id[gi+1])
      );
   end

   // sequencer and result register
   mmga_ctrl #(
      .NumRequesters (NumRequesters),
      .MetricBits    (MetricBits)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_requester_id (req_requester_id),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_grant_count  (rsp_grant_count),
      .rsp_first_id     (rsp_first_id),
      .rsp_second_id    (rsp_second_id),
      .rsp_done_res     (rsp_done_res),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .tail_word        (chain_word[NumRequesters]),
      .tail_id          (chain_id[NumRequesters]),
      .cmd              (cmd)
   );

endmodule

FILE: tb/tb_min_metric_grant_arbiter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_min_metric_grant_arbiter
// Self-checking bench for the min-metric grant arbiter: a directed table
// covers empty picks, tie breaks, pairing, the serve limit and every policy;
// random phases then sweep the register settings under bursty backpressure.
// Each transfer runs through a local arbitration model; its result, or a
// checked row's grant, is queued and matched field by field against rsp_.
// ----------------------------------------------------------------------------
module tb_min_metric_grant_arbiter import mmga_pkg::*;;

   localparam int          NREQ           = NUM_REQUESTERS_DEF;
   localparam logic [31:0] IDLE_METRIC    = 32'hFFFF_FFFF;
   localparam int          PHASES         = 8;
   localparam int          PHASE_ITEMS    = 230;
   localparam int          LONG_HOLD      = 120;
   localparam int          SETTLE_CYCLES  = 4;
   localparam int          TAIL_CYCLES    = NREQ + 8;
   localparam int          WATCHDOG_LIMIT = 2000;

   // one expected rsp_ transfer
   typedef struct packed {
      logic [1:0] grants;
      logic [3:0] first;
      logic [3:0] second;
      logic       done;
   } grant_rec_type;

   typedef enum logic [1:0] {
      ROW_ITEM,
      ROW_CHECKED,
      ROW_CSR
   } row_kind_type;

   typedef struct packed {
      row_kind_type  kind;
      op_type        op;
      logic [3:0]    rid;
      csr_type       reg_idx;
      logic [15:0]   data;
      grant_rec_type want;
   } plan_row_type;

   // directed table: checked rows carry a grant that is easy to work out by hand
   localparam plan_row_type DIRECTED [31] = '{
      '{ROW_CHECKED, OP_PICK,    4'd0,  CSR_POLICY,      16'd0,     '{2'd0, 4'd0,  4'd0, 1'b0}},
      '{ROW_CHECKED, OP_NOP,     4'd15, CSR_POLICY,      16'd0,     '{2'd0, 4'd0,  4'd0, 1'b0}},
      '{ROW_ITEM,    OP_TICK,    4'd0,  CSR_POLICY,      16'd0,     '{2'd0, 4'd0,  4'd0, 1'b0}},
      '{ROW_ITEM,    OP_REQUEST, 4'd15, CSR_POLICY,      16'd0,     '{2'd0, 4'd0,  4'd0, 1'b0}},
      '{ROW_ITEM,    OP_REQUEST, 4'd0,  CSR_POLICY,      16'd0,     '{2'd0, 4'd0,  4'd0, 1'b0}},
      '{ROW_CHECKED, OP_PICK,    4'd0,  CSR_POLICY,      16'd0,     '{2'd1, 4'd0,  4'd0, 1'b0}},
      '{ROW_CHECKED, OP_PICK,    4'd0,  CSR_POLICY,      16'd0,     '{2'd1, 4'd15, 4'd0, 1'b0}},
      '{ROW_CSR,     OP_NOP,     4'd0,  CSR_PAIR_MODE,   16'd1,     '{2'd0, 4'd0,  4'd0, 1'b0}},
      '{ROW_ITEM,    OP_REQUEST, 4'd3,  CSR_POLICY,      16'd0,     '{2'd0, 4'd0,  4'd0, 1'b0}},
      '{ROW_ITEM,    OP_REQUEST, 4'd5,  CSR_POLICY,      16'd0,     '{2'd0, 4'd0,  4'd0, 1'b0}},
      '{ROW_CHECKED, OP_PICK,    4'd0,  CSR_POLICY,      16'd0,     '{2'd0, 4'd0,  4'd0, 1'b0}},
      '{ROW_CHECKED, OP_PICK,    4'd0,  CSR_POLICY,      16'd0,     '{2'd2, 4'd5,  4'd3, 1'b0}},
      '{ROW_ITEM,    OP_REQUEST, 4'd7,  CSR_POLICY,      16'd0,     '{2'd0, 4'd0,  4'd0, 1'b0}},
      '{ROW_ITEM,    OP_PICK,    4'd0,  CSR_POLICY,      16'd0,     '{2'd0, 4'd0,  4'd0, 1'b0}},
      '{ROW_CHECKED, OP_PICK,    4'd0,  CSR_POLICY,      16'd0,     '{2'd0, 4'd0,  4'd0, 1'b0}},
      '{ROW_ITEM,    OP_REQUEST, 4'd7,  CSR_POLICY,      16'd0,     '{2'd0, 4'd0,  4'd0, 1'b0}},
      '{ROW_ITEM,    OP_PICK,    4'd0,  CSR_POLICY,      16'd0,     '{2'd0, 4'd0,  4'd0, 1'b0}},
      '{ROW_CSR,     OP_NOP,     4'd0,  CSR_POLICY,      16'd3,     '{2'd0, 4'd0,  4'd0, 1'b0}},
      '{ROW_CSR,     OP_NOP,     4'd0,  CSR_PAIR_MODE,   16'd0,     '{2'd0, 4'd0,  4'd0, 1'b0}},
      '{ROW_CSR,     OP_NOP,     4'd0,  CSR_SERVE_LIMIT, 16'd0,     '{2'd0, 4'd0,  4'd0, 1'b0}},
      '{ROW_ITEM,    OP_REQUEST, 4'd9,  CSR_POLICY,      16'd0,     '{2'd0, 4'd0,  4'd0, 1'b0}},
      '{ROW_CHECKED, OP_PICK,    4'd0,  CSR_POLICY,      16'd0,     '{2'd0, 4'd0,  4'd0, 1'b1}},
      '{ROW_CSR,     OP_NOP,     4'd0,  CSR_SERVE_LIMIT, 16'hFFFF,  '{2'd0, 4'd0,  4'd0, 1'b0}},
      '{ROW_CSR,     OP_NOP,     4'd0,  CSR_POLICY,      16'd1,     '{2'd0, 4'd0,  4'd0, 1'b0}},
      '{ROW_ITEM,    OP_REQUEST, 4'd15, CSR_POLICY,      16'd0,     '{2'd0, 4'd0,  4'd0, 1'b0}},
      '{ROW_ITEM,    OP_PICK,    4'd0,  CSR_POLICY,      16'd0,     '{2'd0, 4'd0,  4'd0, 1'b0}},
      '{ROW_ITEM,    OP_PICK,    4'd0,  CSR_POLICY,      16'd0,     '{2'd0, 4'd0,  4'd0, 1'b0}},
      '{ROW_CSR,     OP_NOP,     4'd0,  CSR_POLICY,      16'd2,     '{2'd0, 4'd0,  4'd0, 1'b0}},
      '{ROW_ITEM,    OP_TICK,    4'd0,  CSR_POLICY,      16'd0,     '{2'd0, 4'd0,  4'd0, 1'b0}},
      '{ROW_ITEM,    OP_REQUEST, 4'd2,  CSR_POLICY,      16'd0,     '{2'd0, 4'd0,  4'd0, 1'b0}},
      '{ROW_ITEM,    OP_PICK,    4'd0,  CSR_POLICY,      16'd0,     '{2'd0, 4'd0,  4'd0, 1'b0}}
   };

   // dut signals, inputs known from time zero
   logic                  clock            = 1'b0;
   logic                  reset            = 1'b1;
   logic                  req_valid        = 1'b0;
   logic                  req_ready;
   logic [1:0]            req_operation    = 2'd0;
   logic [3:0]            req_requester_id = 4'd0;
   logic                  rsp_valid;
   logic                  rsp_ready        = 1'b0;
   logic [1:0]            rsp_grant_count;
   logic [3:0]            rsp_first_id;
   logic [3:0]            rsp_second_id;
   logic                  rsp_done_res;
   logic                  csr_wr_en        = 1'b0;
   logic [1:0]            csr_index        = 2'd0;
   logic [CSR_DATA_W-1:0] csr_wdata        = '0;

   // arbitration model state and register copy
   logic [31:0] prio_word [NREQ];
   logic [15:0] serve_cnt [NREQ];
   logic [31:0] tick_cnt;
   logic [15:0] grant_total;
   bit          pair_held;
   logic [3:0]  held_req;
   policy_type  cfg_policy;
   bit          cfg_pair;
   logic [15:0] cfg_limit;

   grant_rec_type grants_due [$];
   int            mismatches   = 0;
   int            quiet_cycles = 0;
   bit            gap_on       = 1'b0;
   bit            stall_on     = 1'b0;
   bit            hold_stall   = 1'b0;

   min_metric_grant_arbiter u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_requester_id (req_requester_id),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_grant_count  (rsp_grant_count),
      .rsp_first_id     (rsp_first_id),
      .rsp_second_id    (rsp_second_id),
      .rsp_done_res     (rsp_done_res),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // saturating 16-bit increment
   function automatic logic [15:0] bump(input logic [15:0] v);
      return (v == 16'hFFFF) ? v : v + 16'd1;
   endfunction

   // apply one item to the model and return the grant it produces
   task automatic arbitrate(input op_type op, input logic [3:0] rid,
                            output grant_rec_type res);
      int          best_idx;
      int          i;
      logic [31:0] best;
      logic [31:0] metric;
      res = '0;
      case (op)
         OP_TICK: begin
            tick_cnt = tick_cnt + 32'd1;
         end
         OP_REQUEST: begin
            // metric choice per policy, never landing on the idle value
            case (cfg_policy)
               POL_FEWEST:  metric = {16'd0, serve_cnt[rid]};
               POL_MOST:    metric = IDLE_METRIC - {16'd0, serve_cnt[rid]} - 32'd1;
               POL_ARRIVAL: metric = (tick_cnt == IDLE_METRIC) ? IDLE_METRIC - 32'd1 : tick_cnt;
               default:     metric = {28'd0, rid};
            endcase
            prio_word[rid] = metric;
         end
         OP_PICK: begin
            if (grant_total < cfg_limit) begin
               // smallest word wins, lowest index on ties
               best     = IDLE_METRIC;
               best_idx = -1;
               for (i = 0; i < NREQ; i++) begin
                  if (prio_word[i] < best) begin
                     best     = prio_word[i];
                     best_idx = i;
                  end
               end
               if (best_idx >= 0) begin
                  prio_word[best_idx] = IDLE_METRIC;
                  if (pair_held) begin
                     // complete the pair, whatever pair mode says now
                     pair_held           = 1'b0;
                     serve_cnt[best_idx] = bump(serve_cnt[best_idx]);
                     serve_cnt[held_req] = bump(serve_cnt[held_req]);
                     grant_total         = bump(bump(grant_total));
                     res.grants          = 2'd2;
                     res.first           = best_idx[3:0];
                     res.second          = held_req;
                  end else if (cfg_pair) begin
                     pair_held = 1'b1;
                     held_req  = best_idx[3:0];
                  end else begin
                     serve_cnt[best_idx] = bump(serve_cnt[best_idx]);
                     grant_total         = bump(grant_total);
                     res.grants          = 2'd1;
                     res.first           = best_idx[3:0];
                  end
               end
            end
         end
         default: ;
      endcase
      res.done = (grant_total >= cfg_limit);
   endtask

   // count a failure, print only the first few
   task automatic log_fault(input string what, input logic [3:0] want_v, input logic [3:0] got_v);
      mismatches++;
      if (mismatches <= 10)
         $display("[%0t] mismatch %s: expected %0d, got %0d", $realtime, what, want_v, got_v);
   endtask

   // offer one item and record its expected grant at the transfer
   task automatic push_item(input op_type op, input logic [3:0] rid, input bit typed,
                            input grant_rec_type typed_grant);
      grant_rec_type predicted;
      req_valid        <= 1'b1;
      req_operation    <= op;
      req_requester_id <= rid;
      do @(posedge clock); while (!req_ready);
      arbitrate(op, rid, predicted);
      grants_due.push_back(typed ? typed_grant : predicted);
      @(negedge clock);
   endtask

   // stop offering and wait until every pending grant is back
   task automatic settle_idle();
      req_valid <= 1'b0;
      while (grants_due.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input csr_type idx, input logic [15:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_POLICY:      cfg_policy = policy_type'(value[1:0]);
         CSR_PAIR_MODE:   cfg_pair   = value[0];
         CSR_SERVE_LIMIT: cfg_limit  = value;
         default: ;
      endcase
   endtask

   // receiver: random stall bursts plus one long hold-off on request
   always begin : rsp_side
      int hold;
      @(negedge clock);
      if (hold_stall) begin
         rsp_ready <= 1'b0;
         repeat (LONG_HOLD) @(negedge clock);
         hold_stall = 1'b0;
         rsp_ready <= 1'b1;
      end else if (stall_on && $urandom_range(0, 4) == 0) begin
         rsp_ready <= 1'b0;
         hold = $urandom_range(1, 8);
         repeat (hold - 1) @(negedge clock);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // match each rsp_ transfer against the oldest expectation
   always @(posedge clock) begin : grant_check
      grant_rec_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (grants_due.size() == 0) begin
            log_fault("result with nothing pending, first_id", 4'd0, rsp_first_id);
         end else begin
            want = grants_due.pop_front();
            if (rsp_grant_count !== want.grants)
               log_fault("grant_count", {2'd0, want.grants}, {2'd0, rsp_grant_count});
            if (rsp_first_id !== want.first)
               log_fault("first_id", want.first, rsp_first_id);
            if (rsp_second_id !== want.second)
               log_fault("second_id", want.second, rsp_second_id);
            if (rsp_done_res !== want.done)
               log_fault("done_res", {3'd0, want.done}, {3'd0, rsp_done_res});
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin : stimulus
      int           p;
      int           k;
      int           pct;
      plan_row_type row;
      op_type       op;
      logic [3:0]   rid;
      policy_type   pol;
      logic         pair;
      logic [15:0]  limit;

      // model reset state
      for (k = 0; k < NREQ; k++) begin
         prio_word[k] = IDLE_METRIC;
         serve_cnt[k] = 16'd0;
      end
      tick_cnt    = 32'd0;
      grant_total = 16'd0;
      pair_held   = 1'b0;
      held_req    = 4'd0;
      cfg_policy  = POL_FEWEST;
      cfg_pair    = 1'b0;
      cfg_limit   = SERVE_LIMIT_RST;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed table
      for (k = 0; k < $size(DIRECTED); k++) begin
         row = DIRECTED[k];
         if (row.kind == ROW_CSR) begin
            settle_idle();
            write_csr(row.reg_idx, row.data);
         end else begin
            push_item(row.op, row.rid, row.kind == ROW_CHECKED, row.want);
         end
      end

      // random phases, each under its own register setting
      for (p = 0; p < PHASES; p++) begin
         settle_idle();
         case (p)
            0: begin pol = POL_FEWEST;  pair = 1'b0; limit = 16'hFFFF; end
            1: begin
               pol   = POL_MOST;
               pair  = 1'b1;
               limit = grant_total + 16'($urandom_range(10, 60));
            end
            2: begin pol = POL_ARRIVAL; pair = 1'b0; limit = 16'hFFFF; end
            3: begin pol = POL_FIXED;   pair = 1'b1; limit = 16'hFFFF; end
            4: begin
               pol   = policy_type'($urandom_range(0, 3));
               pair  = 1'($urandom_range(0, 1));
               limit = 16'd0;
            end
            5: begin
               pol   = policy_type'($urandom_range(0, 3));
               pair  = 1'($urandom_range(0, 1));
               limit = grant_total + 16'($urandom_range(5, 40));
            end
            6: begin
               // one grant left with pairing on: the pair overshoots the limit
               pol   = policy_type'($urandom_range(0, 3));
               pair  = 1'b1;
               limit = grant_total + 16'd1;
            end
            default: begin
               pol   = policy_type'($urandom_range(0, 3));
               pair  = 1'($urandom_range(0, 1));
               limit = 16'hFFFF;
            end
         endcase
         write_csr(CSR_POLICY, {14'd0, pol});
         write_csr(CSR_PAIR_MODE, {15'd0, pair});
         write_csr(CSR_SERVE_LIMIT, limit);
         gap_on   = (p % 3 != 1) && (p != PHASES - 1);
         stall_on = (p % 3 != 2) && (p != PHASES - 1);

         for (k = 0; k < PHASE_ITEMS; k++) begin
            // long receiver hold-off so the block backs up into req_ready
            if (p == 2 && k == 60)
               hold_stall = 1'b1;
            // sender pause until the block has drained
            if (p == 5 && k == 100)
               settle_idle();
            if (gap_on && $urandom_range(0, 3) == 0) begin
               req_valid <= 1'b0;
               repeat ($urandom_range(1, 8)) @(negedge clock);
            end
            pct = $urandom_range(0, 99);
            if (pct < 15)
               op = OP_TICK;
            else if (pct < 55)
               op = OP_REQUEST;
            else if (pct < 92)
               op = OP_PICK;
            else
               op = OP_NOP;
            rid = 4'($urandom_range(0, 15));
            push_item(op, rid, 1'b0, '0);
         end
      end

      // drain and let any stray result show up
      settle_idle();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (mismatches == 0 && grants_due.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/core/mmga_pkg.sv
rtl/core/mmga_cell.sv
rtl/core/mmga_ctrl.sv
rtl/core/min_metric_grant_arbiter.sv
tb/tb_min_metric_grant_arbiter.sv
